// ----- hw/rtl/pvw_pkg.sv -----
package pvw_pkg;

    // fixed formats
    localparam int SPAN_W      = 7;
    localparam int VOL_W       = 32;
    localparam int LOG_FRAC    = 24;
    localparam int LOG_CNT_W   = 5;
    localparam int MANT_W      = 32;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 36;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int LN_SHIFT    = 37;
    localparam int DIV_SHIFT   = 42;
    localparam int FOURLN2_W   = 34;
    localparam int QUO_W       = 64;
    localparam int SQRT_STEPS  = 32;

    localparam logic [SPAN_W-1:0]    SPAN_RESET  = 7'd20;
    localparam logic [MUL_B_W-1:0]   LN2_Q32     = 36'h0_B172_17F8;
    localparam logic [MUL_B_W-1:0]   FOURLN2_Q32 = 36'h2_C5C8_5FDF;
    localparam logic [QUO_W-1:0]     SQRT_TOP    = 64'h4000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_LN,
        ST_ROUND,
        ST_TERM,
        ST_OLD,
        ST_UPDATE,
        ST_SCALE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } pvw_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } ds_state_t;

endpackage

// ----- hw/rtl/pvw_if.sv -----
interface pvw_bar_if #(parameter int PRICE_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;

    modport source (output valid, bar_high, bar_low, input ready);
    modport sink   (input valid, bar_high, bar_low, output ready);
endinterface

interface pvw_vol_if;
    logic        valid;
    logic        ready;
    logic [31:0] volatility;
    logic        window_full;

    modport source (output valid, volatility, window_full, input ready);
    modport sink   (input valid, volatility, window_full, output ready);
endinterface

// ----- hw/rtl/parkinson_volatility_window_top.sv -----
// Parkinson high-low volatility over the last span price bars. Each item is one bar
// (bar_high, bar_low) in integer ticks; each item gives exactly one result item with
// volatility = sqrt(sum of ln(high/low)^2 / (4 * span * ln2)) in unsigned Q8.24 and
// window_full. Until span bars have arrived since reset or the last span write the
// result is 0 with window_full low. A bar with a zero price adds a zero term, and a
// bar with high below low counts as if swapped. Span 0 acts as 1, span above
// WINDOW_MAX acts as WINDOW_MAX; every span write empties the window. The block
// handles one bar at a time: ready is high only while idle and the result stays on the
// output until taken. One 32x36 multiplier is shared by both log2 squaring loops, the
// ln scaling, the term square and the divisor. Each price is normalized by shifting
// out its leading zeros before its log2 loop; a bar with a zero price skips the loops
// and the term square. Once the window is full, a serial divider handles each dividend
// bit (sum width plus 42, 97 at the defaults), followed by a bitwise square root.
module parkinson_volatility_window_top
    import pvw_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              span_we,
    input  logic [SPAN_W-1:0] span_wdata,
    pvw_bar_if.sink           bar,
    pvw_vol_if.source         result
);

    localparam int PW    = $clog2(PRICE_BITS);
    localparam int LOGW  = PW + LOG_FRAC;        // log2 in Q.24
    localparam int LNW   = LOGW + 32 - LN_SHIFT; // ln in Q.19
    localparam int TERMW = 2 * LNW;              // term in Q.38
    localparam int NW    = $clog2(WINDOW_MAX + 1);
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int SUMW  = TERMW + NW;
    localparam int DIVW  = NW + FOURLN2_W;
    localparam int PRODW = LOGW + 32;
    localparam logic [PRODW-1:0] LN_ROUND = PRODW'(1) << (LN_SHIFT - 1);

    pvw_state_t               state_reg, state_next;

    // window state
    logic [SPAN_W-1:0]        span_reg;
    logic [NW-1:0]            n_reg;
    logic [AW-1:0]            pos_reg;
    logic [NW-1:0]            bars_reg;
    logic [SUMW-1:0]          sum_reg;
    logic [TERMW-1:0]         ring_mem [WINDOW_MAX];
    logic [TERMW-1:0]         old_reg;

    // per-bar datapath
    logic [PRICE_BITS-1:0]    low_reg;
    logic [PRICE_BITS-1:0]    norm_reg;
    logic [PW-1:0]            p_reg;
    logic [MANT_W-1:0]        mant_reg;
    logic [LOG_FRAC-1:0]      frac_reg;
    logic [LOG_CNT_W-1:0]     cnt_reg;
    logic                     second_reg;
    logic [LOGW-1:0]          a_reg;
    logic [LOGW-1:0]          d_reg;
    logic [PRODW-1:0]         prod_reg;
    logic [LNW-1:0]           ln_reg;
    logic [TERMW-1:0]         term_reg;
    logic [DIVW-1:0]          den_reg;
    logic [VOL_W-1:0]         vol_reg;
    logic                     full_reg;

    // shared multiplier
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_p;

    logic [NW-1:0]            n_eff;
    logic                     zero_price;
    logic [PRICE_BITS+31:0]   norm_ext;
    logic [MANT_W-1:0]        mant_new;
    logic [2*MANT_W-1:0]      sq;
    logic [LOG_FRAC-1:0]      frac_new;
    logic [LOGW-1:0]          b_log;
    logic [PRODW-1:0]         ln_sum;
    logic [AW:0]              old_raw;
    logic [AW-1:0]            old_idx;
    logic                     full_before;
    logic                     full_after;
    logic [NW-1:0]            bars_inc;
    logic                     ds_start;
    logic                     ds_done;
    logic [VOL_W-1:0]         ds_root;

    // span clamp: 0 reads as 1, above the ring depth reads as the depth
    always_comb
    begin
        if (span_reg == '0)
            n_eff = NW'(1);
        else if (32'(span_reg) > WINDOW_MAX)
            n_eff = NW'(WINDOW_MAX);
        else
            n_eff = NW'(span_reg);
    end

    assign zero_price = (bar.bar_high == '0) || (bar.bar_low == '0);

    // top 32 bits of the normalized price form the Q1.31 mantissa
    assign norm_ext = {norm_reg, 32'b0};

    // mantissa squaring step: a carry past 2.0 gives a one bit and a halving
    assign sq       = mul_p[2*MANT_W-1:0];
    assign mant_new = sq[2*MANT_W-1] ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
    assign frac_new = {frac_reg[LOG_FRAC-2:0], sq[2*MANT_W-1]};
    assign b_log    = {p_reg, frac_reg};

    assign ln_sum = prod_reg + LN_ROUND;

    // ring slot that drops out of the window
    assign old_raw = {1'b0, pos_reg} + (AW + 1)'(WINDOW_MAX) - (AW + 1)'(n_reg);
    assign old_idx = (old_raw >= (AW + 1)'(WINDOW_MAX))
                   ? AW'(old_raw - (AW + 1)'(WINDOW_MAX)) : AW'(old_raw);

    assign full_before = bars_reg >= n_reg;
    assign bars_inc    = bars_reg + 1'b1;
    assign full_after  = full_before || (bars_inc >= n_reg);

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (bar.valid)
                    state_next = zero_price ? ST_OLD : ST_NORM;
            end
            ST_NORM:   if (norm_reg[PRICE_BITS-1]) state_next = ST_LOG;
            ST_LOG:
            begin
                if (cnt_reg == '0)
                    state_next = second_reg ? ST_DIFF : ST_NORM;
            end
            ST_DIFF:   state_next = ST_LN;
            ST_LN:     state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_TERM;
            ST_TERM:   state_next = ST_OLD;
            ST_OLD:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = full_after ? ST_SCALE : ST_OUT;
            ST_SCALE:  state_next = ST_START;
            ST_START:  state_next = ST_WAIT;
            ST_WAIT:   if (ds_done) state_next = ST_OUT;
            ST_OUT:    if (result.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshakes and multiplier operand select
    always_comb
    begin
        bar.ready          = (state_reg == ST_IDLE);
        result.valid       = (state_reg == ST_OUT);
        result.volatility  = vol_reg;
        result.window_full = full_reg;
        ds_start           = (state_reg == ST_START);
        mul_a              = '0;
        mul_b              = '0;
        case (state_reg)
            ST_LOG:
            begin
                mul_a = mant_reg;
                mul_b = MUL_B_W'(mant_reg);
            end
            ST_LN:
            begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = LN2_Q32;
            end
            ST_TERM:
            begin
                mul_a = MUL_A_W'(ln_reg);
                mul_b = MUL_B_W'(ln_reg);
            end
            ST_SCALE:
            begin
                mul_a = MUL_A_W'(n_reg);
                mul_b = FOURLN2_Q32;
            end
            default:
            begin
            end
        endcase
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            span_reg  <= SPAN_RESET;
            pos_reg   <= '0;
            bars_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                sum_reg  <= sum_reg + SUMW'(term_reg)
                          - (full_before ? SUMW'(old_reg) : SUMW'(0));
                pos_reg  <= (pos_reg == AW'(WINDOW_MAX - 1)) ? '0 : pos_reg + 1'b1;
                bars_reg <= full_before ? bars_reg : bars_inc;
            end
            // span write empties the window
            if (span_we)
            begin
                span_reg <= span_wdata;
                pos_reg  <= '0;
                bars_reg <= '0;
                sum_reg  <= '0;
            end
        end
    end

    // term ring, registered read of the leaving slot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
            ring_mem[pos_reg] <= term_reg;
        if (state_reg == ST_OLD)
            old_reg <= ring_mem[old_idx];
    end

    // per-bar datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg      <= n_eff;
                norm_reg   <= bar.bar_high;
                low_reg    <= bar.bar_low;
                p_reg      <= PW'(PRICE_BITS - 1);
                second_reg <= 1'b0;
                term_reg   <= '0;
            end
            ST_NORM:
            begin
                if (norm_reg[PRICE_BITS-1])
                begin
                    mant_reg <= norm_ext[PRICE_BITS+31 -: MANT_W];
                    frac_reg <= '0;
                    cnt_reg  <= LOG_CNT_W'(LOG_FRAC - 1);
                end
                else
                begin
                    norm_reg <= norm_reg << 1;
                    p_reg    <= p_reg - 1'b1;
                end
            end
            ST_LOG:
            begin
                mant_reg <= mant_new;
                frac_reg <= frac_new;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0 && !second_reg)
                begin
                    a_reg      <= {p_reg, frac_new};
                    second_reg <= 1'b1;
                    norm_reg   <= low_reg;
                    p_reg      <= PW'(PRICE_BITS - 1);
                end
            end
            ST_DIFF:  d_reg    <= (a_reg >= b_log) ? (a_reg - b_log) : (b_log - a_reg);
            ST_LN:    prod_reg <= mul_p[PRODW-1:0];
            ST_ROUND: ln_reg   <= ln_sum[LN_SHIFT +: LNW];
            ST_TERM:  term_reg <= mul_p[TERMW-1:0];
            ST_UPDATE:
            begin
                full_reg <= full_after;
                vol_reg  <= '0;
            end
            ST_SCALE: den_reg  <= mul_p[DIVW-1:0];
            ST_WAIT:  if (ds_done) vol_reg <= ds_root;
            default:
            begin
            end
        endcase
    end

    pvw_divsqrt #(
        .NUM_W (SUMW),
        .DEN_W (DIVW)
    ) u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ds_start),
        .num   (sum_reg),
        .den   (den_reg),
        .done  (ds_done),
        .root  (ds_root)
    );

endmodule

// ----- hw/rtl/pvw_divsqrt.sv -----
module pvw_divsqrt
    import pvw_pkg::*;
#(
    parameter int NUM_W = 55,
    parameter int DEN_W = 41
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [VOL_W-1:0] root
);

    localparam int NUMX = NUM_W + DIV_SHIFT;
    localparam int CW   = $clog2(NUMX);

    ds_state_t         state_reg, state_next;
    logic [CW-1:0]     cnt_reg;
    logic [NUMX-1:0]   num_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  v_reg;
    logic [QUO_W-1:0]  res_reg;
    logic [QUO_W-1:0]  sq_bit_reg;

    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [QUO_W-1:0]  quo_new;
    logic [QUO_W-1:0]  trial;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {rem_reg, num_reg[NUMX-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign quo_new = {quo_reg[QUO_W-2:0], ge};

    // one root bit per cycle
    assign trial = res_reg + sq_bit_reg;
    assign fits  = v_reg >= trial;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DS_IDLE: if (start) state_next = DS_DIV;
            DS_DIV:  if (cnt_reg == '0) state_next = DS_SQRT;
            DS_SQRT: if (cnt_reg == '0) state_next = DS_DONE;
            DS_DONE: state_next = DS_IDLE;
            default: state_next = DS_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == DS_DONE);
        root = res_reg[VOL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DS_IDLE:
            begin
                num_reg <= {num, {DIV_SHIFT{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CW'(NUMX - 1);
            end
            DS_DIV:
            begin
                // remainder stays below the divisor
                rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
                quo_reg <= quo_new;
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    v_reg      <= quo_new;
                    res_reg    <= '0;
                    sq_bit_reg <= SQRT_TOP;
                    cnt_reg    <= CW'(SQRT_STEPS - 1);
                end
            end
            DS_SQRT:
            begin
                if (fits)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- tb/sv/parkinson_volatility_window_top_tb.sv -----
`timescale 1ns / 1ps

module parkinson_volatility_window_top_tb;
    import pvw_pkg::*;

    localparam int WMAX     = 64;
    localparam int PBITS    = 32;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 400;

    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
    } bar_t;

    typedef struct packed {
        logic [31:0] vol;
        logic        full;
    } vol_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic span_we = 1'b0;
    logic [SPAN_W-1:0] span_wdata = '0;

    pvw_bar_if #(.PRICE_BITS(PBITS)) bar_ch ();
    pvw_vol_if res_ch ();

    parkinson_volatility_window_top #(.WINDOW_MAX(WMAX), .PRICE_BITS(PBITS)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_we    (span_we),
        .span_wdata (span_wdata),
        .bar        (bar_ch.sink),
        .result     (res_ch.source)
    );

    always #5 clk = ~clk;

    // predictor state: ring of squared log ratios, running sum, fill count
    logic [47:0] term_ring [WMAX];
    int unsigned ring_pos;
    logic [55:0] term_sum;
    int unsigned bars_seen;
    logic [6:0]  span_reg;

    bar_t pending_bars[$];
    vol_t expected_vols[$];

    int errors = 0;
    int bars_sent = 0;
    int vols_checked = 0;
    int full_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    // log2 of a nonzero price as Q.24, mantissa squared and truncated each step
    function automatic logic [63:0] price_log2(logic [63:0] x);
        int p;
        logic [63:0] m;
        logic [63:0] r;
        logic [127:0] sq;
        p = 0;
        for (int k = 63; k >= 0; k--)
            if (x[k] && p == 0 && k > 0) p = k;
        m = (p <= 31) ? (x << (31 - p)) : (x >> (p - 31));
        r = 64'(p) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--)
        begin
            sq = m * m;
            m = 64'(sq >> 31);
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [47:0] squared_log_ratio(logic [31:0] hi, logic [31:0] lo);
        logic [63:0] a, b, d, ln;
        if (hi == 0 || lo == 0) return '0;
        a = price_log2(64'(hi));
        b = price_log2(64'(lo));
        d = (a >= b) ? a - b : b - a;
        ln = (d * 64'(LN2_Q32) + (64'd1 << 36)) >> 37;
        return 48'(ln * ln);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned window_len();
        if (span_reg == 0) return 1;
        if (span_reg > WMAX) return WMAX;
        return span_reg;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WMAX; i++) term_ring[i] = '0;
        ring_pos = 0;
        term_sum = '0;
        bars_seen = 0;
    endtask

    task automatic predict_volatility(bar_t b);
        int unsigned n;
        logic [47:0] t;
        logic [127:0] vsq;
        logic [63:0] v;
        vol_t e;
        n = window_len();
        t = squared_log_ratio(b.high, b.low);
        if (bars_seen >= n) term_sum = term_sum - 56'(term_ring[(ring_pos + WMAX - n) % WMAX]);
        term_ring[ring_pos] = t;
        term_sum = term_sum + 56'(t);
        ring_pos = (ring_pos + 1) % WMAX;
        if (bars_seen < n) bars_seen++;
        e = '0;
        if (bars_seen >= n)
        begin
            vsq = (128'(term_sum) << DIV_SHIFT) / (128'(n) * 128'(FOURLN2_Q32));
            v = int_sqrt(64'(vsq));
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            e.vol = v[31:0];
            e.full = 1'b1;
        end
        expected_vols.push_back(e);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %h want %h", what, vols_checked, got, want);
    endtask

    // driver: feeds pending items, random idle gaps per phase
    always @(posedge clk)
    begin
        if (!rst_n)
            bar_ch.valid <= 1'b0;
        else if (!bar_ch.valid || bar_ch.ready)
        begin
            if (bar_ch.valid) bars_sent++;
            if (pending_bars.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                bar_t b;
                b = pending_bars.pop_front();
                predict_volatility(b);
                bar_ch.valid <= 1'b1;
                bar_ch.bar_high <= b.high;
                bar_ch.bar_low <= b.low;
            end
            else
                bar_ch.valid <= 1'b0;
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                vol_t e;
                if (expected_vols.size() == 0)
                begin
                    report_mismatch("unexpected item", res_ch.volatility, 32'd0);
                end
                else
                begin
                    e = expected_vols.pop_front();
                    if (res_ch.volatility !== e.vol)
                        report_mismatch("volatility", res_ch.volatility, e.vol);
                    if (res_ch.window_full !== e.full)
                        report_mismatch("window_full", 32'(res_ch.window_full), 32'(e.full));
                    if (e.full) full_seen++;
                end
                vols_checked++;
            end
            res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
        else
            res_ch.ready <= 1'b0;
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("watchdog expired with %0d results pending", expected_vols.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_price();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return $urandom_range(3, 0);
            2: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            default: return $urandom_range(200000, 1000);
        endcase
    endfunction

    function automatic bar_t rand_bar();
        bar_t b;
        logic [31:0] base;
        if ($urandom_range(9, 0) == 0)
        begin
            b.high = rand_price();
            b.low = rand_price();
        end
        else
        begin
            // realistic bar: low near high
            base = $urandom_range(32'h7FFF_FFFF, 1);
            b.low = base;
            b.high = base + (base >> $urandom_range(20, 3));
            if ($urandom_range(3, 0) == 0) b.high = $urandom();
        end
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_bars.size() > 0 || expected_vols.size() > 0 || bar_ch.valid)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_span(logic [6:0] s);
        @(posedge clk);
        span_we <= 1'b1;
        span_wdata <= s;
        @(posedge clk);
        span_we <= 1'b0;
        span_reg = s;
        clear_window();
    endtask

    initial
    begin
        bar_t b;
        logic [6:0] spans [8];
        bar_ch.valid = 1'b0;
        bar_ch.bar_high = '0;
        bar_ch.bar_low = '0;
        res_ch.ready = 1'b0;
        span_reg = SPAN_RESET;
        clear_window();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset span, extremes, zero prices, swapped high and low
        b = '{32'hFFFF_FFFF, 32'd1};          pending_bars.push_back(b);
        b = '{32'd1, 32'hFFFF_FFFF};          pending_bars.push_back(b);
        b = '{32'd0, 32'd100};                pending_bars.push_back(b);
        b = '{32'd100, 32'd0};                pending_bars.push_back(b);
        b = '{32'd0, 32'd0};                  pending_bars.push_back(b);
        b = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};  pending_bars.push_back(b);
        b = '{32'h8000_0000, 32'h7FFF_FFFF};  pending_bars.push_back(b);
        b = '{32'd3, 32'd2};                  pending_bars.push_back(b);
        for (int i = 0; i < 14; i++) pending_bars.push_back(rand_bar());
        wait_drained();

        // span 0 acts as 1; a span above max is then written and drained with no bars
        write_span(7'd0);
        b = '{32'hFFFF_FFFF, 32'd1}; pending_bars.push_back(b);
        b = '{32'd5, 32'd7};         pending_bars.push_back(b);
        wait_drained();
        write_span(7'd127);
        wait_drained();

        spans = '{7'd1, 7'd64, 7'd2, 7'd100, 7'd7, 7'd33, 7'd0, 7'd16};
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            write_span((ph == 7) ? 7'($urandom_range(64, 1)) : spans[ph]);
            for (int i = 0; i < 190; i++) pending_bars.push_back(rand_bar());
            wait_drained();
        end

        $display("covered %0d bars over several spans and idle patterns", bars_sent);
        $display("checked %0d results, %0d with a full window", vols_checked, full_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/pvw_pkg.sv
hw/rtl/pvw_if.sv
hw/rtl/pvw_divsqrt.sv
hw/rtl/parkinson_volatility_window_top.sv
tb/sv/parkinson_volatility_window_top_tb.sv
